### sv/lad_pkg.sv
package lad_pkg;

    localparam int WORD_W = 32;
    localparam int MODE_W = 3;
    localparam int STAT_W = 3;

    // Request codes carried in s_tuser
    localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_PEEK       = 3'd4;

    // Status codes carried in m_tuser
    localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd2;
    localparam logic [STAT_W-1:0] ST_NO_FRONT = 3'd3;
    localparam logic [STAT_W-1:0] ST_NO_BACK  = 3'd4;

    localparam logic [WORD_W-1:0] NONE_WORD = '1;

    // Output m_tdata: data, rear_data, now_empty, now_full, zero fill to bytes
    localparam int OUT_BITS = 2 * WORD_W + 2;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    // Source of an output data field
    typedef enum logic [1:0] {
        SEL_ZERO = 2'b00,
        SEL_NONE = 2'b01,
        SEL_RAM  = 2'b10
    } sel_t;

    typedef struct packed {
        logic accept;   // take the input word this cycle
        logic load;     // move the pending result into the output register
    } lad_cmd_t;

    typedef struct packed {
        logic out_valid;  // output register holds a word not yet taken
    } lad_stat_t;

endpackage

### sv/linear_array_deque.sv
// Channel   Direction  tdata                                   tuser
// s_*       in         [31:0] value                            [2:0] mode
// m_*       out        [31:0] data, [63:32] rear_data,         [2:0] status
//                      [64] now_empty, [65] now_full, pad 0
//
// Each request is accepted, its entry RAM read is registered, and the result
// then loads into the output register; a peek reads both ends through the
// RAM's two ports. A stalled output holds the result in the output register,
// and the next request is taken as soon as that result has moved into it.
// Reset empties the deque (both indices zero); entry contents are not cleared.
module linear_array_deque #(
    parameter int DEPTH = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [lad_pkg::WORD_W-1:0]     s_tdata,   // [31:0] value
    input  logic [lad_pkg::MODE_W-1:0]     s_tuser,   // [2:0] mode
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [lad_pkg::OUT_W-1:0]      m_tdata,   // data, rear_data, now_empty, now_full
    output logic [lad_pkg::STAT_W-1:0]     m_tuser    // [2:0] status
);

    import lad_pkg::*;

    lad_cmd_t  cmd;
    lad_stat_t stat;

    // Sequencer: takes a word, waits for the RAM read, then loads the output
    lad_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Indices, empty mark, entry RAM and output register
    lad_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .mode     (s_tuser),
        .value    (s_tdata),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

`ifndef SYNTH
    // One request at a time: after a word is taken, hold off the next
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while a request is in flight");

    // An empty-deque status always reports the none word
    a_empty_data: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == ST_EMPTY) |-> (m_tdata[WORD_W-1:0] == NONE_WORD))
        else $error("empty status without none word");

    // A refused push on a full deque leaves it full
    a_full_stays: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == ST_FULL) |-> (m_tdata[2*WORD_W+1] && !m_tdata[2*WORD_W]))
        else $error("full status but deque not full");

    // Full and empty flags never both set
    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[2*WORD_W] && m_tdata[2*WORD_W+1]))
        else $error("now_empty and now_full both set");
`endif

endmodule

### sv/lad_ram.sv
module lad_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

### sv/lad_ctrl.sv
module lad_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic               m_tready,
    input  lad_pkg::lad_stat_t stat,
    output lad_pkg::lad_cmd_t  cmd
);

    import lad_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_LOAD = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_tready   = (state_reg == S_IDLE);
    assign cmd.accept = s_tready && s_tvalid;
    // Load once the output register is free or is being emptied this cycle
    assign cmd.load   = (state_reg == S_LOAD) && (!stat.out_valid || m_tready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.accept)
                begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                if (cmd.load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### sv/lad_dp.sv
module lad_dp #(
    parameter int DEPTH = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  lad_pkg::lad_cmd_t               cmd,
    output lad_pkg::lad_stat_t              stat,
    input  logic [lad_pkg::MODE_W-1:0]      mode,
    input  logic [lad_pkg::WORD_W-1:0]      value,
    input  logic                            m_tready,
    output logic                            m_tvalid,
    output logic [lad_pkg::OUT_W-1:0]       m_tdata,
    output logic [lad_pkg::STAT_W-1:0]      m_tuser
);

    import lad_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam logic [AW-1:0] TOP = AW'(DEPTH - 1);

    logic [AW-1:0] front_reg, front_next;
    logic [AW-1:0] rear_reg,  rear_next;
    logic          empty_reg, empty_next;

    // Pending result between the RAM read and the output register
    sel_t              sel_a_reg,  sel_a_next;
    sel_t              sel_b_reg,  sel_b_next;
    logic [STAT_W-1:0] status_reg, status_next;
    logic              nempty_reg, nfull_reg;
    logic              full;

    logic              out_valid_reg, out_valid_next;
    logic [WORD_W-1:0] data_reg, rdata_reg;
    logic [STAT_W-1:0] ustat_reg;
    logic              oempty_reg, ofull_reg;

    logic              we;
    logic [AW-1:0]     waddr;
    logic [AW-1:0]     raddr_a;
    logic [WORD_W-1:0] ram_a, ram_b;

    lad_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (value),
        .re      (cmd.accept),
        .raddr_a (raddr_a),
        .raddr_b (rear_reg),
        .rdata_a (ram_a),
        .rdata_b (ram_b)
    );

    assign full = !empty_reg && (front_reg == '0) && (rear_reg == TOP);

    always_comb
    begin
        front_next  = front_reg;
        rear_next   = rear_reg;
        empty_next  = empty_reg;
        we          = 1'b0;
        waddr       = front_reg;
        raddr_a     = front_reg;
        status_next = ST_OK;
        sel_a_next  = SEL_ZERO;
        sel_b_next  = SEL_ZERO;
        if (cmd.accept)
        begin
            unique case (mode)
                MODE_PUSH_FRONT, MODE_PUSH_BACK:
                begin
                    priority if (full)
                    begin
                        status_next = ST_FULL;
                    end
                    else if (empty_reg)
                    begin
                        empty_next = 1'b0;
                        front_next = '0;
                        rear_next  = '0;
                        we         = 1'b1;
                        waddr      = '0;
                    end
                    else if (mode == MODE_PUSH_FRONT)
                    begin
                        if (front_reg == '0)
                        begin
                            status_next = ST_NO_FRONT;
                        end
                        else
                        begin
                            front_next = front_reg - 1'b1;
                            we         = 1'b1;
                            waddr      = front_reg - 1'b1;
                        end
                    end
                    else
                    begin
                        if (rear_reg == TOP)
                        begin
                            status_next = ST_NO_BACK;
                        end
                        else
                        begin
                            rear_next = rear_reg + 1'b1;
                            we        = 1'b1;
                            waddr     = rear_reg + 1'b1;
                        end
                    end
                end
                MODE_POP_FRONT, MODE_POP_BACK:
                begin
                    if (empty_reg)
                    begin
                        sel_a_next  = SEL_NONE;
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        sel_a_next = SEL_RAM;
                        raddr_a    = (mode == MODE_POP_FRONT) ? front_reg : rear_reg;
                        priority if (front_reg == rear_reg)
                        begin
                            empty_next = 1'b1;
                            front_next = '0;
                            rear_next  = '0;
                        end
                        else if (mode == MODE_POP_FRONT)
                        begin
                            front_next = front_reg + 1'b1;
                        end
                        else
                        begin
                            rear_next = rear_reg - 1'b1;
                        end
                    end
                end
                MODE_PEEK:
                begin
                    if (empty_reg)
                    begin
                        sel_a_next  = SEL_NONE;
                        sel_b_next  = SEL_NONE;
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        sel_a_next = SEL_RAM;
                        sel_b_next = SEL_RAM;
                    end
                end
                default:
                begin
                    status_next = ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            rear_reg  <= '0;
            empty_reg <= 1'b1;
        end
        else
        begin
            front_reg <= front_next;
            rear_reg  <= rear_next;
            empty_reg <= empty_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            sel_a_reg  <= sel_a_next;
            sel_b_reg  <= sel_b_next;
            status_reg <= status_next;
            nempty_reg <= empty_next;
            nfull_reg  <= !empty_next && (front_next == '0) && (rear_next == TOP);
        end
    end

    function automatic logic [WORD_W-1:0] pick(sel_t sel, logic [WORD_W-1:0] ram);
        logic [WORD_W-1:0] w;
        unique case (sel)
            SEL_RAM:  w = ram;
            SEL_NONE: w = NONE_WORD;
            default:  w = '0;
        endcase
        return w;
    endfunction

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            data_reg   <= pick(sel_a_reg, ram_a);
            rdata_reg  <= pick(sel_b_reg, ram_b);
            ustat_reg  <= status_reg;
            oempty_reg <= nempty_reg;
            ofull_reg  <= nfull_reg;
        end
    end

    assign stat.out_valid = out_valid_reg;
    assign m_tvalid       = out_valid_reg;
    assign m_tuser        = ustat_reg;
    assign m_tdata        = {{(OUT_W - OUT_BITS){1'b0}}, ofull_reg, oempty_reg,
                             rdata_reg, data_reg};

endmodule

### tb/sv/deque_checker.sv
`timescale 1ns / 100ps

module deque_checker #(
    parameter int DEPTH = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    input  logic                       s_tready,
    input  logic [lad_pkg::WORD_W-1:0] s_tdata,   // [31:0] value
    input  logic [lad_pkg::MODE_W-1:0] s_tuser,   // [2:0] mode
    input  logic                       m_tvalid,
    input  logic                       m_tready,
    input  logic [lad_pkg::OUT_W-1:0]  m_tdata,   // data, rear_data, now_empty, now_full
    input  logic [lad_pkg::STAT_W-1:0] m_tuser,   // [2:0] status
    output int                         errors,
    output int                         outstanding
);

    import lad_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);

    typedef struct packed {
        logic [WORD_W-1:0] data;
        logic [WORD_W-1:0] rear_data;
        logic [STAT_W-1:0] status;
        logic              now_empty;
        logic              now_full;
    } deque_result_t;

    logic [WORD_W-1:0] entries [DEPTH];
    logic [IDX_W-1:0]  front_idx;
    logic [IDX_W-1:0]  rear_idx;
    logic              is_empty;
    deque_result_t     awaited_results [$];

    function automatic logic deque_full();
        return !is_empty && front_idx == '0 && rear_idx == IDX_W'(DEPTH - 1);
    endfunction

    // Advance the shadow deque by one request and return the word it must produce.
    function automatic deque_result_t serve_request(input logic [MODE_W-1:0] mode,
                                                    input logic [WORD_W-1:0] value);
        deque_result_t res;
        res = '0;
        res.status = ST_OK;
        unique case (mode)
            MODE_PUSH_FRONT, MODE_PUSH_BACK:
            begin
                if (deque_full())
                begin
                    res.status = ST_FULL;
                end
                else if (is_empty)
                begin
                    is_empty = 1'b0;
                    front_idx = '0;
                    rear_idx = '0;
                    entries[0] = value;
                end
                else if (mode == MODE_PUSH_FRONT)
                begin
                    if (front_idx == '0)
                    begin
                        res.status = ST_NO_FRONT;
                    end
                    else
                    begin
                        front_idx = front_idx - 1'b1;
                        entries[front_idx] = value;
                    end
                end
                else
                begin
                    if (rear_idx == IDX_W'(DEPTH - 1))
                    begin
                        res.status = ST_NO_BACK;
                    end
                    else
                    begin
                        rear_idx = rear_idx + 1'b1;
                        entries[rear_idx] = value;
                    end
                end
            end
            MODE_POP_FRONT, MODE_POP_BACK:
            begin
                if (is_empty)
                begin
                    res.data = NONE_WORD;
                    res.status = ST_EMPTY;
                end
                else
                begin
                    res.data = entries[mode == MODE_POP_FRONT ? front_idx : rear_idx];
                    if (front_idx == rear_idx)
                    begin
                        is_empty = 1'b1;
                        front_idx = '0;
                        rear_idx = '0;
                    end
                    else if (mode == MODE_POP_FRONT)
                    begin
                        front_idx = front_idx + 1'b1;
                    end
                    else
                    begin
                        rear_idx = rear_idx - 1'b1;
                    end
                end
            end
            MODE_PEEK:
            begin
                if (is_empty)
                begin
                    res.data = NONE_WORD;
                    res.rear_data = NONE_WORD;
                    res.status = ST_EMPTY;
                end
                else
                begin
                    res.data = entries[front_idx];
                    res.rear_data = entries[rear_idx];
                end
            end
            default: ;
        endcase
        res.now_empty = is_empty;
        res.now_full = deque_full();
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        deque_result_t want;
        if (!rst_n)
        begin
            is_empty = 1'b1;
            front_idx = '0;
            rear_idx = '0;
            awaited_results.delete();
            errors = 0;
            outstanding <= 0;
        end
        else
        begin
            // Predict first: a result word never leaves in the cycle its request enters.
            if (s_tvalid && s_tready)
                awaited_results.push_back(serve_request(s_tuser, s_tdata));
            if (m_tvalid && m_tready)
            begin
                if (awaited_results.size() == 0)
                begin
                    report_mismatch("result word with no request outstanding");
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (m_tdata[WORD_W-1:0] !== want.data)
                        report_mismatch($sformatf("data %h, want %h",
                                                  m_tdata[WORD_W-1:0], want.data));
                    if (m_tdata[2*WORD_W-1:WORD_W] !== want.rear_data)
                        report_mismatch($sformatf("rear_data %h, want %h",
                                                  m_tdata[2*WORD_W-1:WORD_W], want.rear_data));
                    if (m_tuser !== want.status)
                        report_mismatch($sformatf("status %0d, want %0d",
                                                  m_tuser, want.status));
                    if (m_tdata[2*WORD_W] !== want.now_empty)
                        report_mismatch($sformatf("now_empty %b, want %b",
                                                  m_tdata[2*WORD_W], want.now_empty));
                    if (m_tdata[2*WORD_W+1] !== want.now_full)
                        report_mismatch($sformatf("now_full %b, want %b",
                                                  m_tdata[2*WORD_W+1], want.now_full));
                end
            end
            outstanding <= awaited_results.size();
        end
    end

endmodule

### tb/sv/linear_array_deque_test.sv
`timescale 1ns / 100ps

module linear_array_deque_test;

    import lad_pkg::*;

    localparam int DEPTH = 16;
    localparam int RANDOM_WORDS = 1700;
    localparam int HOLD_CYCLES = 150;
    localparam int DRAIN_CYCLES = 8;

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [WORD_W-1:0] s_tdata;   // [31:0] value
    logic [MODE_W-1:0] s_tuser;   // [2:0] mode
    logic              m_tvalid;
    logic              m_tready;
    logic [OUT_W-1:0]  m_tdata;   // [31:0] data, [63:32] rear_data, [64] now_empty,
                                  // [65] now_full, zero pad above
    logic [STAT_W-1:0] m_tuser;   // [2:0] status

    int errors;
    int outstanding;

    // Idle rates in percent, and the receiver hold-off request (cycles)
    int snd_idle = 0;
    int rcv_idle = 0;
    int hold_req = 0;
    int hold_left = 0;

    linear_array_deque #(
        .DEPTH(DEPTH)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    deque_checker #(
        .DEPTH(DEPTH)
    ) chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .errors     (errors),
        .outstanding(outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit: far beyond the slowest legal run with every stall at its worst.
    initial
    begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    // Receiver: stall at random, or hold off entirely while a hold-off is counting down.
    initial
    begin
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req > 0)
            begin
                hold_left = hold_req;
                hold_req = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= ($urandom_range(0, 99) >= rcv_idle);
            end
        end
    end

    // Offer one request word and hold it until the block takes it. Random idle
    // cycles go in front, so a lowered tvalid never shares a step with a raised one.
    task automatic send_word(input logic [MODE_W-1:0] mode, input logic [WORD_W-1:0] value);
        while ($urandom_range(0, 99) < snd_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= mode;
        s_tdata <= value;
        do @(posedge clk); while (!s_tready);
    endtask

    // Drop valid, then hold until every outstanding result word has come back.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        wait (outstanding == 0);
    endtask

    // Bias values toward the sign and range extremes.
    function automatic logic [WORD_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return NONE_WORD;
            3:       return '0;
            default: return $urandom();
        endcase
    endfunction

    // Mostly pushes and pops in the bias given, some peeks, a few unused codes.
    function automatic logic [MODE_W-1:0] pick_mode(input int push_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 3)
            return MODE_W'(MODE_PEEK + 1 + $urandom_range(0, 2));
        if (roll < 13)
            return MODE_PEEK;
        if ($urandom_range(0, 99) < push_pct)
            return $urandom_range(0, 1) ? MODE_PUSH_FRONT : MODE_PUSH_BACK;
        return $urandom_range(0, 1) ? MODE_POP_FRONT : MODE_POP_BACK;
    endfunction

    // Edge cases: empty reads, the first push, both boundary refusals, full, unused codes.
    task automatic run_directed();
        send_word(MODE_PEEK, pick_value());
        send_word(MODE_POP_FRONT, pick_value());
        send_word(MODE_POP_BACK, pick_value());
        send_word(MODE_PUSH_FRONT, 32'h8000_0000);
        send_word(MODE_PUSH_FRONT, 32'h7FFF_FFFF);
        for (int k = 1; k < DEPTH; k++)
            send_word(MODE_PUSH_BACK, (k == DEPTH - 1) ? NONE_WORD : 32'h1 << (2 * k));
        send_word(MODE_PUSH_BACK, 32'h1234_5678);
        send_word(MODE_PUSH_FRONT, 32'h9ABC_DEF0);
        send_word(MODE_PEEK, '0);
        send_word(MODE_POP_FRONT, NONE_WORD);
        send_word(MODE_PUSH_BACK, 32'h5555_5555);
        send_word(MODE_PUSH_FRONT, 32'hAAAA_AAAA);
        send_word(MODE_POP_BACK, '0);
        for (int k = 1; k <= 3; k++)
            send_word(MODE_W'(MODE_PEEK + k), pick_value());
    endtask

    // One idling phase: push-heavy, pop-heavy and balanced stretches in turn, a long
    // receiver hold-off a third of the way in, a full drain two thirds in.
    task automatic run_phase(input int words, input int s_pct, input int r_pct);
        int push_pct;
        snd_idle = s_pct;
        rcv_idle = r_pct;
        for (int i = 0; i < words; i++)
        begin
            case ((i / 40) % 3)
                0:       push_pct = 75;
                1:       push_pct = 25;
                default: push_pct = 50;
            endcase
            if (i == words / 3)
                hold_req = HOLD_CYCLES;
            if (i == 2 * words / 3)
                drain_results();
            send_word(pick_mode(push_pct), pick_value());
        end
    endtask

    initial
    begin
        rst_n <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= MODE_PUSH_FRONT;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        snd_idle = 6;
        rcv_idle = 49;
        run_directed();
        run_phase(RANDOM_WORDS / 3, 6, 49);
        run_phase(RANDOM_WORDS / 3, 49, 6);
        run_phase(RANDOM_WORDS - 2 * (RANDOM_WORDS / 3), 0, 0);

        // Let the last results drain, then allow for the block's latency.
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && outstanding == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
